@@ rtl/nups_pkg.sv @@
package nups_pkg;

  localparam int IdW    = 31;
  localparam int CoordW = 32;
  localparam int CmdW   = 2;
  localparam int StatW  = 3;
  localparam int SqW    = 2 * CoordW;
  localparam int DistW  = SqW + 2;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_NEXT  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_LOADED  = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_CHOSEN  = 3'd2,
    STAT_NONE    = 3'd3,
    STAT_CLEARED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    logic   used;
    logic   visited;
    point_t pt;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic write_hit;
    logic mark_hit;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic [IdW-1:0]           point_id;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
  } in_data_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdW-1:0]   chosen_id;
  } out_data_t;

endpackage

@@ rtl/nups_chan_if.sv @@
interface nups_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/nearest_unvisited_point_select_unit.sv @@
// Channel  Dir  Payload                                    Transaction
// in_i     in   command, point_id, pos_x, pos_y, pos_z     valid && ready
// out_o    out  status, chosen_id                          valid && ready
//
// Load and clear are handled without leaving the idle state; every command but the unused code yields one result.
// A next request rotates the whole cell chain once past a four-stage distance pipeline,
// then drains the pipeline before the pick is written to the output register.
// Reset clears every used and visited mark at once; no clearing pass is needed.
// A finished result sits in an output register; a new transaction is taken while it
// is being read, and a finishing next request waits for that register to free up.
module nearest_unvisited_point_select_unit #(
  parameter int MAX_POINTS = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  nups_chan_if.sink   in_i,
  nups_chan_if.source out_o
);
  import nups_pkg::*;

  localparam int CntW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  state_e state_q, state_d;

  entry_t             chain [MAX_POINTS];
  logic [MAX_POINTS-1:0] hit;
  entry_t             feed;
  cell_ctrl_t         ctrl;
  logic [IdW-1:0]     key_id;
  point_t             wdata;
  in_data_t           in_d;

  logic               in_acc, out_free, any_hit, full, insert;
  logic [CntW-1:0]    cnt_q;
  logic               scan_last;

  logic               pipe_v, best_clr, dist_busy, found;
  point_t             best;

  logic               started_q;
  point_t             last_q;
  logic               last_from_load, take, clr_state;

  logic               res_we;
  status_e            res_status;
  logic [IdW-1:0]     res_id;
  logic               out_valid_q;
  logic [StatW-1:0]   out_status_q;
  logic [IdW-1:0]     out_id_q;

  assign in_d     = in_i.data;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_acc   = in_i.valid && in_i.ready;

  assign wdata.id = in_d.point_id;
  assign wdata.x  = in_d.pos_x;
  assign wdata.y  = in_d.pos_y;
  assign wdata.z  = in_d.pos_z;

  // Used entries always fill the chain from the first cell, so the last cell
  // being used means the table is full.
  assign any_hit = |hit;
  assign full    = chain[MAX_POINTS-1].used;

  always_comb begin
    feed = chain[MAX_POINTS-1];
    if (insert) begin
      feed.used    = 1'b1;
      feed.visited = 1'b0;
      feed.pt      = wdata;
    end
  end

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    nups_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .key_id_i (key_id),
      .wdata_i  (wdata),
      .prev_i   ((g == 0) ? feed : chain[(g == 0) ? 0 : g - 1]),
      .entry_o  (chain[g]),
      .hit_o    (hit[g])
    );
  end

  nups_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (best_clr),
    .valid_i   (pipe_v),
    .head_i    (chain[MAX_POINTS-1]),
    .started_i (started_q),
    .last_i    (last_q),
    .busy_o    (dist_busy),
    .found_o   (found),
    .best_o    (best)
  );

  assign scan_last = (cnt_q == CntW'(MAX_POINTS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_d.command == CMD_NEXT)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!dist_busy) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    key_id         = in_d.point_id;
    insert         = 1'b0;
    pipe_v         = 1'b0;
    best_clr       = 1'b0;
    res_we         = 1'b0;
    res_status     = STAT_LOADED;
    res_id         = '0;
    last_from_load = 1'b0;
    take           = 1'b0;
    clr_state      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(in_d.command))
            CMD_LOAD: begin
              res_we = 1'b1;
              if (any_hit) begin
                ctrl.write_hit = 1'b1;
                last_from_load = started_q && (in_d.point_id == last_q.id);
              end else if (!full) begin
                ctrl.shift = 1'b1;
                insert     = 1'b1;
              end else begin
                res_status = STAT_FULL;
              end
            end
            CMD_NEXT: begin
              best_clr = 1'b1;
            end
            CMD_CLEAR: begin
              ctrl.clear = 1'b1;
              clr_state  = 1'b1;
              res_we     = 1'b1;
              res_status = STAT_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ctrl.shift = 1'b1;
        pipe_v     = 1'b1;
      end
      S_DRAIN: ;
      S_FINISH: begin
        key_id = best.id;
        if (out_free) begin
          res_we = 1'b1;
          if (found) begin
            ctrl.mark_hit = 1'b1;
            take          = 1'b1;
            res_status    = STAT_CHOSEN;
            res_id        = best.id;
          end else begin
            res_status = STAT_NONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (clr_state) begin
        started_q <= 1'b0;
      end else if (take) begin
        started_q <= 1'b1;
      end
      if (res_we) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The last point's coordinates follow a reload of that same id.
  always_ff @(posedge clk_i) begin
    if (take) begin
      last_q <= best;
    end else if (last_from_load) begin
      last_q.x <= wdata.x;
      last_q.y <= wdata.y;
      last_q.z <= wdata.z;
    end
    if (res_we) begin
      out_status_q <= res_status;
      out_id_q     <= res_id;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data.status    = out_status_q;
  assign out_o.data.chosen_id = out_id_q;

endmodule

@@ rtl/nups_cell.sv @@
module nups_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nups_pkg::cell_ctrl_t  ctrl_i,
  input  logic [nups_pkg::IdW-1:0] key_id_i,
  input  nups_pkg::point_t      wdata_i,
  input  nups_pkg::entry_t      prev_i,
  output nups_pkg::entry_t      entry_o,
  output logic                  hit_o
);
  import nups_pkg::*;

  logic   used_q, visited_q;
  point_t pt_q;

  assign hit_o = used_q && (pt_q.id == key_id_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= 1'b0;
      visited_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      used_q    <= 1'b0;
      visited_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      used_q    <= prev_i.used;
      visited_q <= prev_i.visited;
    end else if (ctrl_i.write_hit && hit_o) begin
      visited_q <= 1'b0;
    end else if (ctrl_i.mark_hit && hit_o) begin
      visited_q <= 1'b1;
    end
  end

  // A reload keeps the id and replaces only the coordinates.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      pt_q <= prev_i.pt;
    end else if (ctrl_i.write_hit && hit_o) begin
      pt_q.x <= wdata_i.x;
      pt_q.y <= wdata_i.y;
      pt_q.z <= wdata_i.z;
    end
  end

  assign entry_o.used    = used_q;
  assign entry_o.visited = visited_q;
  assign entry_o.pt      = pt_q;

endmodule

@@ rtl/nups_dist.sv @@
module nups_dist (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic                       valid_i,
  input  nups_pkg::entry_t           head_i,
  input  logic                       started_i,
  input  nups_pkg::point_t           last_i,
  output logic                       busy_o,
  output logic                       found_o,
  output nups_pkg::point_t           best_o
);
  import nups_pkg::*;

  function automatic logic [CoordW-1:0] abs_diff(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    logic [CoordW:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    if (d[CoordW]) begin
      d = ~d + {{CoordW{1'b0}}, 1'b1};
    end
    return d[CoordW-1:0];
  endfunction

  logic              s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  point_t            s1_pt_q, s2_pt_q, s3_pt_q, s4_pt_q;
  logic [CoordW-1:0] s1_mx_q, s1_my_q, s1_mz_q;
  logic [SqW-1:0]    s2_sx_q, s2_sy_q, s2_sz_q;
  logic [DistW-1:0]  s3_sxy_q, s3_sz_q, s4_sum_q;
  logic              found_q;
  point_t            best_q;
  logic [DistW-1:0]  best_sum_q;

  logic              cand;
  logic [CoordW-1:0] mx, my, mz;
  logic [SqW-1:0]    sqx, sqy, sqz;
  logic              better;

  assign cand = valid_i && head_i.used && !head_i.visited;

  // Before the first pick every distance counts as zero, so the id decides.
  always_comb begin
    mx = '0;
    my = '0;
    mz = '0;
    if (started_i) begin
      mx = abs_diff(head_i.pt.x, last_i.x);
      my = abs_diff(head_i.pt.y, last_i.y);
      mz = abs_diff(head_i.pt.z, last_i.z);
    end
  end

  assign sqx = s1_mx_q * s1_mx_q;
  assign sqy = s1_my_q * s1_my_q;
  assign sqz = s1_mz_q * s1_mz_q;

  assign better = !found_q || (s4_sum_q < best_sum_q) ||
                  ((s4_sum_q == best_sum_q) && (s4_pt_q.id < best_q.id));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      s1_v_q <= cand;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      if (clr_i) begin
        found_q <= 1'b0;
      end else if (s4_v_q && better) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pt_q  <= head_i.pt;
    s1_mx_q  <= mx;
    s1_my_q  <= my;
    s1_mz_q  <= mz;
    s2_pt_q  <= s1_pt_q;
    s2_sx_q  <= sqx;
    s2_sy_q  <= sqy;
    s2_sz_q  <= sqz;
    s3_pt_q  <= s2_pt_q;
    s3_sxy_q <= {2'b00, s2_sx_q} + {2'b00, s2_sy_q};
    s3_sz_q  <= {2'b00, s2_sz_q};
    s4_pt_q  <= s3_pt_q;
    s4_sum_q <= s3_sxy_q + s3_sz_q;
    if (s4_v_q && better) begin
      best_q     <= s4_pt_q;
      best_sum_q <= s4_sum_q;
    end
  end

  assign busy_o  = s1_v_q || s2_v_q || s3_v_q || s4_v_q;
  assign found_o = found_q;
  assign best_o  = best_q;

endmodule

@@ tb/testbench.sv @@
module testbench;
  import nups_pkg::*;

  localparam int TABLE_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 650;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;

  // The one command code that the package leaves without a name; the block drops it.
  localparam logic [CmdW-1:0]   CMD_UNUSED = 2'd3;
  localparam logic [CoordW-1:0] C_MAX      = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] C_MIN      = 32'h8000_0000;
  localparam logic [IdW-1:0]    ID_MAX     = '1;

  typedef enum {GAP_NONE, GAP_SOURCE, GAP_SINK, GAP_BOTH} gap_mode_e;

  typedef struct {
    in_data_t  item;
    bit        typed;
    out_data_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  nups_chan_if #(.T(in_data_t))  in_ch ();
  nups_chan_if #(.T(out_data_t)) out_ch ();

  nearest_unvisited_point_select_unit #(
    .MAX_POINTS(TABLE_DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the point table.
  logic [IdW-1:0]    tbl_id [TABLE_DEPTH];
  logic [CoordW-1:0] tbl_x [TABLE_DEPTH];
  logic [CoordW-1:0] tbl_y [TABLE_DEPTH];
  logic [CoordW-1:0] tbl_z [TABLE_DEPTH];
  bit                tbl_used [TABLE_DEPTH];
  bit                tbl_visited [TABLE_DEPTH];
  int                tour_last;
  bit                tour_started;

  out_data_t pending_results[$];
  plan_row_t plan[$];
  gap_mode_e gap_mode;
  int        issued_items;
  int        directed_items;
  int        mismatch_count = 0;
  int        stall_cycles = 0;

  function automatic logic [SqW-1:0] axis_sq(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    logic [CoordW:0] diff;
    logic [CoordW:0] mag;
    logic [SqW-1:0]  wide;
    diff = {a[CoordW-1], a} - {b[CoordW-1], b};
    mag  = diff[CoordW] ? -diff : diff;
    wide = SqW'(mag);
    return wide * wide;
  endfunction

  function automatic logic [DistW-1:0] span_sq(int s, int t);
    logic [DistW-1:0] acc;
    acc = DistW'(axis_sq(tbl_x[s], tbl_x[t]));
    acc = acc + DistW'(axis_sq(tbl_y[s], tbl_y[t]));
    acc = acc + DistW'(axis_sq(tbl_z[s], tbl_z[t]));
    return acc;
  endfunction

  // Updates the shadow table for one command; returns 0 when no result follows.
  function automatic bit select_outcome(input in_data_t d, output out_data_t res);
    int               slot;
    int               best;
    bit               found;
    logic [DistW-1:0] span;
    logic [DistW-1:0] best_span;
    res = '0;
    case (d.command)
      CMD_LOAD: begin
        slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (slot < 0 && tbl_used[i] && tbl_id[i] == d.point_id) slot = i;
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (slot < 0 && !tbl_used[i]) slot = i;
        end
        if (slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          tbl_used[slot]    = 1'b1;
          tbl_visited[slot] = 1'b0;
          tbl_id[slot]      = d.point_id;
          tbl_x[slot]       = d.pos_x;
          tbl_y[slot]       = d.pos_y;
          tbl_z[slot]       = d.pos_z;
          res.status        = STAT_LOADED;
        end
        return 1'b1;
      end
      CMD_NEXT: begin
        found     = 1'b0;
        best      = 0;
        best_span = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_used[i] && !tbl_visited[i]) begin
            if (!tour_started) begin
              if (!found || tbl_id[i] < tbl_id[best]) begin
                best  = i;
                found = 1'b1;
              end
            end else begin
              span = span_sq(tour_last, i);
              if (!found || span < best_span ||
                  (span == best_span && tbl_id[i] < tbl_id[best])) begin
                best      = i;
                best_span = span;
                found     = 1'b1;
              end
            end
          end
        end
        if (!found) begin
          res.status = STAT_NONE;
        end else begin
          tbl_visited[best] = 1'b1;
          tour_last         = best;
          tour_started      = 1'b1;
          res.status        = STAT_CHOSEN;
          res.chosen_id     = tbl_id[best];
        end
        return 1'b1;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          tbl_used[i]    = 1'b0;
          tbl_visited[i] = 1'b0;
        end
        tour_last    = 0;
        tour_started = 1'b0;
        res.status   = STAT_CLEARED;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int source_gap_pct();
    case (gap_mode)
      GAP_SOURCE: return 53;
      GAP_BOTH:   return 11;
      default:    return 0;
    endcase
  endfunction

  function automatic int sink_gap_pct();
    case (gap_mode)
      GAP_SINK: return 53;
      GAP_BOTH: return 11;
      default:  return 0;
    endcase
  endfunction

  function automatic in_data_t pack_item(logic [CmdW-1:0] cmd, logic [IdW-1:0] id,
                                         logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                         logic [CoordW-1:0] z);
    in_data_t d;
    d.command  = cmd;
    d.point_id = id;
    d.pos_x    = x;
    d.pos_y    = y;
    d.pos_z    = z;
    return d;
  endfunction

  function automatic void add_row(logic [CmdW-1:0] cmd, logic [IdW-1:0] id,
                                  logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                  logic [CoordW-1:0] z, bit typed = 1'b0,
                                  logic [StatW-1:0] st = STAT_LOADED,
                                  logic [IdW-1:0] cid = '0);
    plan_row_t row;
    row.item           = pack_item(cmd, id, x, y, z);
    row.typed          = typed;
    row.want.status    = st;
    row.want.chosen_id = cid;
    plan.push_back(row);
  endfunction

  function automatic logic [CoordW-1:0] pick_coord(int style);
    int v;
    case (style)
      0: v = int'($urandom_range(16)) - 8;
      1: v = $urandom();
      2: begin
        case ($urandom_range(5))
          0: v = C_MAX;
          1: v = C_MIN;
          2: v = 0;
          3: v = -1;
          4: v = 1;
          default: v = $urandom();
        endcase
      end
      default: v = int'($urandom_range(200000)) - 100000;
    endcase
    return v;
  endfunction

  function automatic logic [IdW-1:0] pick_id(int style);
    case (style)
      0: return IdW'($urandom_range(15));
      1: return IdW'($urandom());
      default: return IdW'($urandom_range(1000, 1063));
    endcase
  endfunction

  function automatic in_data_t any_item(logic [CmdW-1:0] cmd);
    return pack_item(cmd, IdW'($urandom()), $urandom(), $urandom(), $urandom());
  endfunction

  task automatic send(in_data_t item, bit typed = 1'b0, out_data_t want = '0);
    out_data_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < source_gap_pct()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (select_outcome(item, predicted)) begin
      pending_results.push_back(typed ? want : predicted);
      issued_items++;
    end
  endtask

  task automatic send_noise();
    send(any_item(CmdW'($urandom_range(3))));
  endtask

  // One tour: optional clear, a batch of loads, then next requests, mostly past the end.
  task automatic run_tour(int size);
    int             coord_style;
    int             id_style;
    int             nexts;
    logic [IdW-1:0] id;
    logic [IdW-1:0] known[$];
    coord_style = $urandom_range(3);
    id_style    = (size > 16) ? 1 : $urandom_range(2);
    if ($urandom_range(9) < 7) send(any_item(CMD_CLEAR));
    for (int k = 0; k < size; k++) begin
      if (known.size() > 0 && $urandom_range(9) == 0) begin
        id = known[$urandom_range(known.size() - 1)];
      end else begin
        id = pick_id(id_style);
      end
      known.push_back(id);
      send(pack_item(CMD_LOAD, id, pick_coord(coord_style), pick_coord(coord_style),
                     pick_coord(coord_style)));
      if ($urandom_range(19) == 0) send(any_item(CMD_NEXT));
      if ($urandom_range(29) == 0) send_noise();
    end
    nexts = ($urandom_range(5) == 0) ? $urandom_range(size) : size + $urandom_range(2);
    for (int k = 0; k < nexts; k++) begin
      case ($urandom_range(19))
        0: send(pack_item(CMD_LOAD, known[$urandom_range(known.size() - 1)],
                          pick_coord(coord_style), pick_coord(coord_style),
                          pick_coord(coord_style)));
        1: send_noise();
        default: ;
      endcase
      send(any_item(CMD_NEXT));
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_gap_pct());
  end

  always @(posedge clk) begin
    out_data_t got;
    out_data_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, got status %0d id %0d",
                 $time, got.status, got.chosen_id);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, got.status);
          mismatch_count++;
        end
        if (got.chosen_id !== want.chosen_id) begin
          $display("%0t: chosen_id mismatch: expected %0d, got %0d",
                   $time, want.chosen_id, got.chosen_id);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("nearest_unvisited_point_select_unit verification failed");
      $finish;
    end
  end

  initial begin
    int progress;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    rst_n          = 1'b0;
    gap_mode       = GAP_NONE;
    issued_items   = 0;
    tour_last      = 0;
    tour_started   = 1'b0;

    add_row(CMD_NEXT, 0, 0, 0, 0, 1'b1, STAT_NONE, 0);
    add_row(CMD_CLEAR, 0, 0, 0, 0, 1'b1, STAT_CLEARED, 0);
    add_row(CMD_LOAD, 1, 0, 0, 0, 1'b1, STAT_LOADED, 0);
    add_row(CMD_LOAD, 9, 5, 0, 0, 1'b1, STAT_LOADED, 0);
    add_row(CMD_LOAD, 4, 0, 0, -5, 1'b1, STAT_LOADED, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 1'b1, STAT_CHOSEN, 1);
    // Points 9 and 4 lie at the same distance; the smaller id wins.
    add_row(CMD_NEXT, 0, 0, 0, 0, 1'b1, STAT_CHOSEN, 4);
    add_row(CMD_NEXT, 0, 0, 0, 0, 1'b1, STAT_CHOSEN, 9);
    add_row(CMD_NEXT, 0, 0, 0, 0, 1'b1, STAT_NONE, 0);
    // Reloading a known id makes it selectable again.
    add_row(CMD_LOAD, 4, 0, 0, -5, 1'b1, STAT_LOADED, 0);
    add_row(CMD_UNUSED, ID_MAX, '1, C_MIN, C_MAX);
    add_row(CMD_NEXT, 0, 0, 0, 0, 1'b1, STAT_CHOSEN, 4);
    add_row(CMD_CLEAR, ID_MAX, '1, '1, '1, 1'b1, STAT_CLEARED, 0);
    add_row(CMD_LOAD, ID_MAX, C_MAX, C_MIN, 0, 1'b1, STAT_LOADED, 0);
    add_row(CMD_LOAD, 0, C_MIN, C_MAX, C_MAX, 1'b1, STAT_LOADED, 0);
    add_row(CMD_LOAD, 100, C_MIN, C_MIN, C_MIN, 1'b1, STAT_LOADED, 0);
    add_row(CMD_LOAD, 200, C_MAX, C_MAX, C_MAX, 1'b1, STAT_LOADED, 0);
    add_row(CMD_LOAD, 201, C_MAX, C_MAX, 0, 1'b1, STAT_LOADED, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 1'b1, STAT_CHOSEN, 0);
    // Distances here overflow 64 bits; the predictor decides the order.
    add_row(CMD_NEXT, 0, 0, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 1'b1, STAT_NONE, 0);
    add_row(CMD_CLEAR, 0, 0, 0, 0, 1'b1, STAT_CLEARED, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send(plan[i].item, plan[i].typed, plan[i].want);
    directed_items = issued_items;

    // The first tour sends more loads than the table has cells, to reach the full case.
    run_tour(TABLE_DEPTH + 6);
    progress = issued_items - directed_items;
    while (progress < RANDOM_ITEMS) begin
      gap_mode = gap_mode_e'((progress * 4 / RANDOM_ITEMS > 3) ? 3
                                                               : progress * 4 / RANDOM_ITEMS);
      if ($urandom_range(7) == 0) begin
        run_tour($urandom_range(40, TABLE_DEPTH + 6));
      end else begin
        run_tour($urandom_range(1, 12));
      end
      progress = issued_items - directed_items;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("nearest_unvisited_point_select_unit verification clean");
    end else begin
      $display("nearest_unvisited_point_select_unit verification failed");
    end
    $finish;
  end

endmodule
